[design/lmc_pkg.sv]
// lmc_pkg: shared types, constants and helpers for the layout metric combiner
// used by every module of the combiner and by its port checker
package lmc_pkg;

  // metric field width (the field widths of the ports follow from it)
  localparam int unsigned METRIC_BITS = 16;
  // configuration register width and bus sizes
  localparam int unsigned CFG_BITS    = 16;
  localparam int unsigned DATA_BITS   = 32;
  localparam int unsigned ADDR_BITS   = 3;

  typedef logic [METRIC_BITS-1:0] metric_w_t;
  // one extra bit so a sum of two metrics never wraps
  typedef logic [METRIC_BITS:0]   sum_t;
  typedef logic [CFG_BITS-1:0]    cfg_w_t;

  typedef enum logic [1:0] {
    ACT_STACK  = 2'd0,
    ACT_BESIDE = 2'd1,
    ACT_FILL   = 2'd2,
    ACT_PASS   = 2'd3
  } action_t;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_PAGE_WIDTH  = 1'b0,
    REG_PAGE_HEIGHT = 1'b1
  } reg_idx_t;

  localparam cfg_w_t PAGE_WIDTH_RESET  = cfg_w_t'(80);
  localparam cfg_w_t PAGE_HEIGHT_RESET = cfg_w_t'(65535);

  // command payload
  typedef struct packed {
    logic [1:0] action;
    metric_w_t  left_height;
    metric_w_t  left_first;
    metric_w_t  left_middle;
    metric_w_t  left_last;
    metric_w_t  right_height;
    metric_w_t  right_first;
    metric_w_t  right_middle;
    metric_w_t  right_last;
    metric_w_t  fill_shift;
  } in_t;

  // result payload
  typedef struct packed {
    metric_w_t out_height;
    metric_w_t out_first;
    metric_w_t out_middle;
    metric_w_t out_last;
    metric_w_t out_total;
    logic      fits_page;
    logic      left_dominates;
    logic      overflow;
  } out_t;

  // page limits handed from the register block to the pipeline
  typedef struct packed {
    cfg_w_t page_width;
    cfg_w_t page_height;
  } cfg_t;

  // first stage: operand classes, raw sums and dominance
  typedef struct packed {
    action_t   action;
    logic      pass_a;
    logic      pass_b;
    logic      a_one;
    logic      a_two;
    logic      b_one;
    logic      b_two;
    logic      dom;
    metric_w_t ah;
    metric_w_t af;
    metric_w_t am;
    metric_w_t al;
    metric_w_t bh;
    metric_w_t bf;
    metric_w_t bm;
    metric_w_t bl;
    sum_t      sum_h;
    sum_t      sum_ff;
    sum_t      sum_lf;
    sum_t      sum_lm;
    sum_t      sum_sm;
    sum_t      sum_ll;
    sum_t      sum_ls;
  } prep_t;

  // second stage: combined, saturated metric
  typedef struct packed {
    metric_w_t h;
    metric_w_t f;
    metric_w_t m;
    metric_w_t l;
    logic      ov;
    logic      dom;
  } merge_t;

  function automatic sum_t widen(metric_w_t x);
    return {1'b0, x};
  endfunction

  function automatic sum_t sum_max(sum_t x, sum_t y);
    return (x < y) ? y : x;
  endfunction

  function automatic metric_w_t metric_max(metric_w_t x, metric_w_t y);
    return (x < y) ? y : x;
  endfunction

  // clamp to the metric maximum
  function automatic metric_w_t sat(sum_t v);
    return v[METRIC_BITS] ? {METRIC_BITS{1'b1}} : v[METRIC_BITS-1:0];
  endfunction

endpackage

[design/lmc_regs.sv]
// lmc_regs: apb-style register block holding the page limits
// depends on lmc_pkg
module lmc_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lmc_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [lmc_pkg::DATA_BITS-1:0]  pwdata,
  output logic [lmc_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  output lmc_pkg::cfg_t                  cfg
);

  lmc_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = lmc_pkg::reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.page_width  <= lmc_pkg::PAGE_WIDTH_RESET;
      cfg.page_height <= lmc_pkg::PAGE_HEIGHT_RESET;
    end else if (wr) begin
      unique case (idx)
        lmc_pkg::REG_PAGE_WIDTH:  cfg.page_width  <= pwdata[lmc_pkg::CFG_BITS-1:0];
        lmc_pkg::REG_PAGE_HEIGHT: cfg.page_height <= pwdata[lmc_pkg::CFG_BITS-1:0];
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      lmc_pkg::REG_PAGE_WIDTH:
        prdata = {{(lmc_pkg::DATA_BITS-lmc_pkg::CFG_BITS){1'b0}}, cfg.page_width};
      lmc_pkg::REG_PAGE_HEIGHT:
        prdata = {{(lmc_pkg::DATA_BITS-lmc_pkg::CFG_BITS){1'b0}}, cfg.page_height};
    endcase
  end

endmodule

[design/lmc_prep.sv]
// lmc_prep: first pipeline stage, operand classes, all raw sums and dominance
// depends on lmc_pkg
module lmc_prep (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  lmc_pkg::in_t   in_data,
  output logic           out_valid,
  output lmc_pkg::prep_t out_data
);

  lmc_pkg::prep_t prep_next;
  logic           a_empty;
  logic           b_empty;

  assign a_empty = (in_data.left_height == '0);
  assign b_empty = (in_data.right_height == '0);

  // classify operands and form every sum the combiners may need
  always_comb begin
    prep_next.action = lmc_pkg::action_t'(in_data.action);
    prep_next.pass_a = (in_data.action == lmc_pkg::ACT_PASS) || (b_empty && !a_empty);
    prep_next.pass_b = !prep_next.pass_a && a_empty;
    prep_next.a_one  = (in_data.left_height == lmc_pkg::METRIC_BITS'(1));
    prep_next.a_two  = (in_data.left_height == lmc_pkg::METRIC_BITS'(2));
    prep_next.b_one  = (in_data.right_height == lmc_pkg::METRIC_BITS'(1));
    prep_next.b_two  = (in_data.right_height == lmc_pkg::METRIC_BITS'(2));
    prep_next.dom    = (prep_next.a_one == prep_next.b_one)
                       && (in_data.left_height <= in_data.right_height)
                       && (in_data.left_first  <= in_data.right_first)
                       && (in_data.left_middle <= in_data.right_middle)
                       && (in_data.left_last   <= in_data.right_last);
    prep_next.ah     = in_data.left_height;
    prep_next.af     = in_data.left_first;
    prep_next.am     = in_data.left_middle;
    prep_next.al     = in_data.left_last;
    prep_next.bh     = in_data.right_height;
    prep_next.bf     = in_data.right_first;
    prep_next.bm     = in_data.right_middle;
    prep_next.bl     = in_data.right_last;
    prep_next.sum_h  = lmc_pkg::widen(in_data.left_height) + lmc_pkg::widen(in_data.right_height);
    prep_next.sum_ff = lmc_pkg::widen(in_data.left_first) + lmc_pkg::widen(in_data.right_first);
    prep_next.sum_lf = lmc_pkg::widen(in_data.left_last) + lmc_pkg::widen(in_data.right_first);
    prep_next.sum_lm = lmc_pkg::widen(in_data.left_last) + lmc_pkg::widen(in_data.right_middle);
    prep_next.sum_sm = lmc_pkg::widen(in_data.fill_shift) + lmc_pkg::widen(in_data.right_middle);
    prep_next.sum_ll = lmc_pkg::widen(in_data.left_last) + lmc_pkg::widen(in_data.right_last);
    prep_next.sum_ls = lmc_pkg::widen(in_data.right_last) + lmc_pkg::widen(in_data.fill_shift);
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= prep_next;
  end

endmodule

[design/lmc_merge.sv]
// lmc_merge: second pipeline stage, combiner case rules and saturation
// depends on lmc_pkg
module lmc_merge (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  lmc_pkg::prep_t  in_data,
  output logic            out_valid,
  output lmc_pkg::merge_t out_data
);

  lmc_pkg::sum_t   rh;
  lmc_pkg::sum_t   rf;
  lmc_pkg::sum_t   rm;
  lmc_pkg::sum_t   rl;
  lmc_pkg::sum_t   af;
  lmc_pkg::sum_t   am;
  lmc_pkg::sum_t   al;
  lmc_pkg::sum_t   bf;
  lmc_pkg::sum_t   bm;
  lmc_pkg::sum_t   bfm;
  lmc_pkg::sum_t   h_less;
  lmc_pkg::sum_t   f_join;
  lmc_pkg::merge_t merge_next;
  logic            a1;
  logic            a2;
  logic            b1;
  logic            b2;

  assign af     = lmc_pkg::widen(in_data.af);
  assign am     = lmc_pkg::widen(in_data.am);
  assign al     = lmc_pkg::widen(in_data.al);
  assign bf     = lmc_pkg::widen(in_data.bf);
  assign bm     = lmc_pkg::widen(in_data.bm);
  assign bfm    = lmc_pkg::sum_max(bf, bm);
  assign h_less = in_data.sum_h - lmc_pkg::sum_t'(1);
  assign a1     = in_data.a_one;
  assign a2     = in_data.a_two;
  assign b1     = in_data.b_one;
  assign b2     = in_data.b_two;
  // side by side joins the first lines only when left is a single line
  assign f_join = a1 ? in_data.sum_ff : af;

  // pick the combined metric
  always_comb begin
    rh = lmc_pkg::widen(in_data.ah);
    rf = af;
    rm = am;
    rl = al;
    if (in_data.pass_a) begin
      rh = lmc_pkg::widen(in_data.ah);
    end else if (in_data.pass_b) begin
      rh = lmc_pkg::widen(in_data.bh);
      rf = bf;
      rm = bm;
      rl = lmc_pkg::widen(in_data.bl);
    end else begin
      unique case (in_data.action)
        lmc_pkg::ACT_STACK: begin
          rh = in_data.sum_h;
          rf = af;
          rl = lmc_pkg::widen(in_data.bl);
          priority if (a1 && b1) begin
            rm = af;
          end else if (a1) begin
            rm = bfm;
          end else if (a2 && b1) begin
            rm = al;
          end else if (b1) begin
            rm = lmc_pkg::sum_max(al, am);
          end else if (a2) begin
            rm = lmc_pkg::sum_max(al, bfm);
          end else begin
            rm = lmc_pkg::sum_max(lmc_pkg::sum_max(am, al), bfm);
          end
        end
        lmc_pkg::ACT_BESIDE: begin
          rh = h_less;
          rf = f_join;
          rl = in_data.sum_ll;
          priority if (a1 && (b1 || b2)) begin
            rm = in_data.sum_ff;
          end else if (b1) begin
            rm = am;
          end else if (a1) begin
            rm = in_data.sum_lm;
          end else if (a2) begin
            rm = lmc_pkg::sum_max(in_data.sum_lf, in_data.sum_lm);
          end else begin
            rm = lmc_pkg::sum_max(am, lmc_pkg::sum_max(in_data.sum_lf, in_data.sum_lm));
          end
        end
        lmc_pkg::ACT_FILL: begin
          rh = h_less;
          rf = f_join;
          rl = b1 ? in_data.sum_ll : in_data.sum_ls;
          priority if (a1 && (b1 || b2)) begin
            rm = in_data.sum_ff;
          end else if (a1) begin
            rm = in_data.sum_sm;
          end else if (a2 && b1) begin
            rm = af;
          end else if (a2 && b2) begin
            rm = in_data.sum_lf;
          end else if (a2) begin
            rm = lmc_pkg::sum_max(in_data.sum_lf, in_data.sum_sm);
          end else if (b1) begin
            rm = am;
          end else if (b2) begin
            rm = lmc_pkg::sum_max(am, in_data.sum_lf);
          end else begin
            rm = lmc_pkg::sum_max(am, lmc_pkg::sum_max(in_data.sum_lf, in_data.sum_sm));
          end
        end
        lmc_pkg::ACT_PASS: begin
          rh = lmc_pkg::widen(in_data.ah);
        end
      endcase
    end
  end

  // saturate and flag
  always_comb begin
    merge_next.h   = lmc_pkg::sat(rh);
    merge_next.f   = lmc_pkg::sat(rf);
    merge_next.m   = lmc_pkg::sat(rm);
    merge_next.l   = lmc_pkg::sat(rl);
    merge_next.ov  = rh[lmc_pkg::METRIC_BITS] | rf[lmc_pkg::METRIC_BITS]
                     | rm[lmc_pkg::METRIC_BITS] | rl[lmc_pkg::METRIC_BITS];
    merge_next.dom = in_data.dom;
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= merge_next;
  end

endmodule

[design/lmc_finish.sv]
// lmc_finish: last pipeline stage, total width, page fit and result register
// depends on lmc_pkg
module lmc_finish (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  lmc_pkg::merge_t in_data,
  input  lmc_pkg::cfg_t   cfg,
  output logic            out_valid,
  output lmc_pkg::out_t   out_data
);

  lmc_pkg::out_t     result_next;
  lmc_pkg::metric_w_t total;

  assign total = lmc_pkg::metric_max(in_data.f, lmc_pkg::metric_max(in_data.m, in_data.l));

  // assemble the result
  always_comb begin
    result_next.out_height     = in_data.h;
    result_next.out_first      = in_data.f;
    result_next.out_middle     = in_data.m;
    result_next.out_last       = in_data.l;
    result_next.out_total      = total;
    result_next.fits_page      = (total <= cfg.page_width) && (in_data.h <= cfg.page_height);
    result_next.left_dominates = in_data.dom;
    result_next.overflow       = in_data.ov;
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= result_next;
  end

endmodule

[design/layout_metric_combiner_core.sv]
// layout_metric_combiner_core: top level of the layout metric combiner
// depends on lmc_pkg, lmc_regs, lmc_prep, lmc_merge, lmc_finish
//
// Usage
//   command channel: drive cmd and raise start; a transaction is taken at every
//   rising edge with start high and busy low. busy stays low, so one command
//   may be issued in every cycle.
//   result channel: done is high for exactly one cycle while result holds the
//   combined metric, total width, page fit, dominance and overflow flags.
//   a command taken at an edge passes the stage registers for operand sums,
//   case selection with saturation, and total width with page compare, in
//   that order, and is then on result with done high.
//   throughput: one transaction per cycle, set by the three-stage pipeline.
//   config: page_width at byte 0, page_height at byte 4 on the apb port, with
//   zero wait states; write them only while no transaction is in flight.
//   reset: rst (synchronous) empties the pipeline and restores page_width 80
//   and page_height 65535; commands issued during reset are dropped.
//   the receiver cannot stall, a result must be captured in its done cycle.
module layout_metric_combiner_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  lmc_pkg::in_t                   cmd,
  output logic                           done,
  output lmc_pkg::out_t                  result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lmc_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [lmc_pkg::DATA_BITS-1:0]  pwdata,
  output logic [lmc_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready
);

  lmc_pkg::cfg_t   cfg;
  lmc_pkg::prep_t  prep;
  lmc_pkg::merge_t merge;
  logic            accept;
  logic            prep_valid;
  logic            merge_valid;

  // pipeline never holds off a command
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // configuration registers
  lmc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage one: sums and classes
  lmc_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_data   (cmd),
    .out_valid (prep_valid),
    .out_data  (prep)
  );

  // stage two: combiner selection and saturation
  lmc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_data   (prep),
    .out_valid (merge_valid),
    .out_data  (merge)
  );

  // stage three: total, page fit, result register
  lmc_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (merge_valid),
    .in_data   (merge),
    .cfg       (cfg),
    .out_valid (done),
    .out_data  (result)
  );

endmodule

[design/lmc_checker.sv]
// lmc_checker: port-level checks for the layout metric combiner
// depends on lmc_pkg; bound to layout_metric_combiner_core
module lmc_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input lmc_pkg::in_t  cmd,
  input logic          done,
  input lmc_pkg::out_t result
);

  // every accepted transaction comes out with done raised
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("accepted transaction produced no result after three cycles");

  // a pass-through never saturates
  a_no_ov_on_pass: assert property (@(posedge clk) disable iff (rst)
    (done && result.overflow) |->
      ($past(cmd.action, 3) != lmc_pkg::ACT_PASS
       && $past(cmd.left_height, 3) != '0 && $past(cmd.right_height, 3) != '0))
    else $error("overflow raised on a pass-through transaction");

  // empty left operand hands the right one through
  a_empty_left: assert property (@(posedge clk) disable iff (rst)
    (done && $past(cmd.left_height, 3) == '0 && $past(cmd.action, 3) != lmc_pkg::ACT_PASS) |->
      (result.out_height == $past(cmd.right_height, 3)
       && result.out_first == $past(cmd.right_first, 3)
       && result.out_last == $past(cmd.right_last, 3)))
    else $error("empty left operand did not pass the right one through");

  // dominance needs left height no larger than right
  a_dominance: assert property (@(posedge clk) disable iff (rst)
    (done && result.left_dominates) |->
      ($past(cmd.left_height, 3) <= $past(cmd.right_height, 3)))
    else $error("left dominates with a larger height");

endmodule

bind layout_metric_combiner_core lmc_checker u_lmc_checker (.*);
